@@ design/dcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, constants and the CRC byte update shared by the decimal record
// CRC checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 8;
    localparam int INDEX_W = 5;
    localparam int DC_W    = 5;
    localparam int CRC_W   = 16;

    // Value store capacity per record
    localparam int MAX_VALUES = 32;
    localparam int VCNT_W     = $clog2(MAX_VALUES + 1);
    // Width wide enough for value count, data_count + 2 and the index
    localparam int CMP_W      = (VCNT_W > DC_W + 1) ? VCNT_W : DC_W + 1;

    // Register reset
    localparam logic [DC_W-1:0] DC_RESET = DC_W'(8);

    // CRC-16/CCITT-FALSE
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    // ASCII digit bounds
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Result kinds
    typedef enum logic {
        KIND_VALUE   = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    // One result item
    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  value_index;
        logic                crc_ok;
        logic                overflow;
        logic                last;
    } t_result;

    // Up to two results from one character, slot 0 first
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    // One byte through the CRC, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [VALUE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/dcc_if.sv @@
// ----------------------------------------------------------------------------
// dcc_if
// Valid/ready channels of the checker: characters in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcc_in_if;
    logic                        valid;
    logic                        ready;
    logic [dcc_pkg::CHAR_W-1:0]  char_in;
    logic                        end_of_record;

    modport source (output valid, output char_in, output end_of_record, input ready);
    modport sink   (input valid, input char_in, input end_of_record, output ready);
endinterface

interface dcc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [dcc_pkg::VALUE_W-1:0]  value;
    logic [dcc_pkg::INDEX_W-1:0]  value_index;
    logic                         crc_ok;
    logic                         overflow;
    logic                         last;

    modport source (output valid, output kind, output value, output value_index,
                    output crc_ok, output overflow, output last, input ready);
    modport sink   (input valid, input kind, input value, input value_index,
                    input crc_ok, input overflow, input last, output ready);
endinterface

`default_nettype wire

@@ design/decimal_record_crc_checker.sv @@
// ----------------------------------------------------------------------------
// decimal_record_crc_checker
// Parses decimal values from a character stream and checks the trailing
// CRC-16/CCITT-FALSE bytes of each record.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake       Payload
//  i_in      in   valid/ready     char_in[7:0], end_of_record
//  o_out     out  valid/ready     kind, value[7:0], value_index[4:0],
//                                 crc_ok, overflow, last
//  i_cfg_*   in   write enable    data_count[4:0]
//
//  One character per cycle: it is registered, then stepped through the
//  parser (byte CRC and accumulate) into a four-entry result queue.
//  A character that yields a value and a verdict gives two output items;
//  input stalls only when the queue lacks room for two items.
//  An accepted character passes the input register, then the result queue.
//  Synchronous active-low reset clears record state, queue and sets
//  data_count to 8; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_record_crc_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    dcc_in_if.sink                         i_in,
    dcc_out_if.source                      o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [dcc_pkg::DC_W-1:0]  i_cfg_data
);

    logic [dcc_pkg::DC_W-1:0]   r_data_count;
    logic                       r_in_valid, n_in_valid;
    logic [dcc_pkg::CHAR_W-1:0] r_char;
    logic                       r_eor;
    logic                       room, step, accept;
    dcc_pkg::t_push             push;

    // Input stage control
    always_comb begin
        step       = r_in_valid && room;
        i_in.ready = !r_in_valid || step;
        accept     = i_in.valid && i_in.ready;
        n_in_valid = accept || (r_in_valid && !step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_data_count <= dcc_pkg::DC_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_data_count <= i_cfg_data;
            end
        end
    end

    // Input payload register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_in.char_in;
            r_eor  <= i_in.end_of_record;
        end
    end

    dcc_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_char       (r_char),
        .i_eor        (r_eor),
        .i_data_count (r_data_count),
        .o_push       (push)
    );

    dcc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ design/dcc_parse.sv @@
// ----------------------------------------------------------------------------
// dcc_parse
// Record state and per-character step: digit accumulate, value emit,
// CRC update over the data values, verdict on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [dcc_pkg::CHAR_W-1:0]    i_char,
    input  wire logic                          i_eor,
    input  wire logic [dcc_pkg::DC_W-1:0]      i_data_count,
    output dcc_pkg::t_push                     o_push
);

    logic [dcc_pkg::VALUE_W-1:0] r_acc,  n_acc;
    logic                        r_in_num, n_in_num;
    logic [dcc_pkg::VCNT_W-1:0]  r_vcnt, n_vcnt;
    logic [dcc_pkg::CRC_W-1:0]   r_crc,  n_crc;
    logic [dcc_pkg::VALUE_W-1:0] r_rec0, n_rec0;
    logic [dcc_pkg::VALUE_W-1:0] r_rec1, n_rec1;
    logic                        r_ovf,  n_ovf;

    logic                        is_digit;
    logic [3:0]                  digit;
    logic [dcc_pkg::VALUE_W-1:0] acc10;
    logic                        emit, full, store, feed;
    logic [dcc_pkg::VCNT_W-1:0]  a_vcnt;
    logic [dcc_pkg::CRC_W-1:0]   a_crc;
    logic [dcc_pkg::VALUE_W-1:0] a_rec0, a_rec1;
    logic                        a_ovf;
    logic [dcc_pkg::CMP_W-1:0]   vcnt_x, dc_x;
    logic                        ok;
    dcc_pkg::t_result            val_res, ver_res;

    // Character decode and accumulate (acc*10 as two shifts)
    always_comb begin
        is_digit = (i_char >= dcc_pkg::CHAR_ZERO) && (i_char <= dcc_pkg::CHAR_NINE);
        digit    = 4'(i_char - dcc_pkg::CHAR_ZERO);
        acc10    = {r_acc[4:0], 3'b000} + {r_acc[6:0], 1'b0} + {4'b0000, digit};
    end

    // Value handling
    always_comb begin
        vcnt_x = dcc_pkg::CMP_W'(r_vcnt);
        dc_x   = dcc_pkg::CMP_W'(i_data_count);
        emit   = !is_digit && r_in_num;
        full   = (r_vcnt >= dcc_pkg::VCNT_W'(dcc_pkg::MAX_VALUES));
        store  = emit && !full;
        feed   = store && (vcnt_x < dc_x);
        a_vcnt = store ? dcc_pkg::VCNT_W'(r_vcnt + 1'b1) : r_vcnt;
        a_crc  = feed ? dcc_pkg::crc_byte(r_crc, r_acc) : r_crc;
        a_rec0 = store ? r_rec1 : r_rec0;
        a_rec1 = store ? r_acc  : r_rec1;
        a_ovf  = r_ovf || (emit && full);
    end

    // Verdict on state after this character's value
    always_comb begin
        ok = !a_ovf
          && (dcc_pkg::CMP_W'(a_vcnt) == dcc_pkg::CMP_W'(dc_x + 2'd2))
          && (a_rec0 == a_crc[7:0])
          && (a_rec1 == a_crc[15:8]);
    end

    // Result items
    always_comb begin
        val_res.kind        = dcc_pkg::KIND_VALUE;
        val_res.value       = r_acc;
        val_res.value_index = vcnt_x[dcc_pkg::INDEX_W-1:0];
        val_res.crc_ok      = 1'b0;
        val_res.overflow    = a_ovf;
        val_res.last        = 1'b0;

        ver_res.kind        = dcc_pkg::KIND_VERDICT;
        ver_res.value       = '0;
        ver_res.value_index = '0;
        ver_res.crc_ok      = ok;
        ver_res.overflow    = a_ovf;
        ver_res.last        = 1'b1;

        o_push.push0 = i_step && (emit || i_eor);
        o_push.push1 = i_step && emit && i_eor;
        o_push.res0  = emit ? val_res : ver_res;
        o_push.res1  = ver_res;
    end

    // Next record state
    always_comb begin
        if (i_eor) begin
            n_acc    = '0;
            n_in_num = 1'b0;
            n_vcnt   = '0;
            n_crc    = dcc_pkg::CRC_INIT;
            n_rec0   = '0;
            n_rec1   = '0;
            n_ovf    = 1'b0;
        end else begin
            n_acc    = is_digit ? acc10 : '0;
            n_in_num = is_digit;
            n_vcnt   = a_vcnt;
            n_crc    = a_crc;
            n_rec0   = a_rec0;
            n_rec1   = a_rec1;
            n_ovf    = a_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_in_num <= 1'b0;
            r_vcnt   <= '0;
            r_crc    <= dcc_pkg::CRC_INIT;
            r_rec0   <= '0;
            r_rec1   <= '0;
            r_ovf    <= 1'b0;
        end else if (i_step) begin
            r_acc    <= n_acc;
            r_in_num <= n_in_num;
            r_vcnt   <= n_vcnt;
            r_crc    <= n_crc;
            r_rec0   <= n_rec0;
            r_rec1   <= n_rec1;
            r_ovf    <= n_ovf;
        end
    end

endmodule

`default_nettype wire

@@ design/dcc_result_fifo.sv @@
// ----------------------------------------------------------------------------
// dcc_result_fifo
// Small result queue: takes up to two items per cycle, gives one per cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_result_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dcc_pkg::t_push i_push,
    output logic                o_room,
    dcc_out_if.source           o_out
);

    dcc_pkg::t_result           r_mem [dcc_pkg::FIFO_DEPTH];
    logic [dcc_pkg::FPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [dcc_pkg::FPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [dcc_pkg::FCNT_W-1:0] r_count,  n_count;
    logic                       pop;
    logic [1:0]                 n_push;
    logic [dcc_pkg::FPTR_W-1:0] wr_ptr1;
    dcc_pkg::t_result           head;

    // Room for a full two-item push
    assign o_room = (r_count <= dcc_pkg::FCNT_W'(dcc_pkg::FIFO_DEPTH - 2));

    // Output side
    always_comb begin
        head              = r_mem[r_rd_ptr];
        o_out.valid       = (r_count != '0);
        o_out.kind        = head.kind;
        o_out.value       = head.value;
        o_out.value_index = head.value_index;
        o_out.crc_ok      = head.crc_ok;
        o_out.overflow    = head.overflow;
        o_out.last        = head.last;
    end

    // Pointer and count update
    always_comb begin
        pop      = o_out.valid && o_out.ready;
        n_push   = {1'b0, i_push.push0} + {1'b0, i_push.push1};
        wr_ptr1  = dcc_pkg::FPTR_W'(r_wr_ptr + 1'b1);
        n_wr_ptr = dcc_pkg::FPTR_W'(r_wr_ptr + n_push);
        n_rd_ptr = pop ? dcc_pkg::FPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = dcc_pkg::FCNT_W'(r_count + n_push - {1'b0, pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

endmodule

`default_nettype wire

@@ design/dcc_checker.sv @@
// ----------------------------------------------------------------------------
// dcc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         i_out_kind,
    input wire logic [dcc_pkg::VALUE_W-1:0]  i_out_value,
    input wire logic [dcc_pkg::INDEX_W-1:0]  i_out_index,
    input wire logic                         i_out_crc_ok,
    input wire logic                         i_out_last
);

    // Queue is empty the cycle after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_value) && $stable(i_out_index) && $stable(i_out_crc_ok))
        else $error("stalled result changed");

    // Verdict carries last and no value fields
    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind |-> i_out_last && (i_out_value == '0)
            && (i_out_index == '0))
        else $error("malformed verdict");

    // Value result never marks last or a pass
    a_value_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_kind |-> !i_out_last && !i_out_crc_ok)
        else $error("malformed value result");

endmodule

bind decimal_record_crc_checker dcc_checker u_dcc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.kind),
    .i_out_value  (o_out.value),
    .i_out_index  (o_out.value_index),
    .i_out_crc_ok (o_out.crc_ok),
    .i_out_last   (o_out.last)
);

`default_nettype wire
